FILE: rtl/core/rhtt_pkg.sv
package rhtt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_FIND  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_HIT   = 2'd1;
	localparam logic [1:0] ST_NOHIT = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic REG_ADJUST_X = 1'b0;
	localparam logic REG_ADJUST_Y = 1'b1;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic signed [15:0] h;
		logic signed [15:0] w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rect_geom_t;

	typedef struct packed {
		logic [31:0] word;
		logic [7:0]  hold;
		logic [7:0]  hover;
		logic [7:0]  click;
		rect_geom_t  geom;
	} rect_entry_t;

	function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		if (s[16] != s[15]) begin
			sat_add16 = s[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sat_add16 = s[15:0];
		end
	endfunction

endpackage

FILE: rtl/core/rect_hit_test_table.sv
// Channel   Signals                                            Direction
// request   start, busy, req_type, pos_x, pos_y, rect_width,   in (busy out)
//           rect_height, click_cmd, hover_cmd, hold_cmd, user_data
// config    cfg_we, cfg_idx, cfg_wdata                         in
// result    done, status, hit_index, hit_click_cmd,            out
//           hit_hover_cmd, hit_hold_cmd, hit_data
//
// Add, clear, other types and a find on an empty table: done the cycle after the beat.
// Find over n entries: one table RAM read per cycle, newest first; done is registered
// after the check of slot 0, earlier on a hit. busy is high during the scan only.
// arst_n clears the entry count, adjust registers and control; no RAM clearing.
// done pulses for one cycle; the receiver cannot stall, a new beat may go in then.
module rect_hit_test_table
	import rhtt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] rect_width,
	input  logic signed [15:0] rect_height,
	input  logic [7:0]         click_cmd,
	input  logic [7:0]         hover_cmd,
	input  logic [7:0]         hold_cmd,
	input  logic signed [31:0] user_data,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic [1:0]         status,
	output logic [3:0]         hit_index,
	output logic [7:0]         hit_click_cmd,
	output logic [7:0]         hit_hover_cmd,
	output logic [7:0]         hit_hold_cmd,
	output logic signed [31:0] hit_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(rect_entry_t);

	state_t state_q, state_d;

	logic signed [15:0] adjust_x_q;
	logic signed [15:0] adjust_y_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic               issuing_q;
	logic               chk_s1;
	logic [AW-1:0]      slot_s1;
	logic signed [15:0] px_q;
	logic signed [15:0] py_q;
	logic               done_q;

	logic               accept;
	logic               full;
	logic               empty;
	logic               hit;
	logic               mem_we;
	logic               count_inc;
	logic               count_clr;
	logic               scan_load;
	logic               finish;
	logic               fin_hit;
	logic [1:0]         fin_status;
	rect_entry_t        wr_entry;
	rect_entry_t        rd_entry;
	logic [EW-1:0]      rd_raw;
	logic [31:0]        slot_ext;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(TABLE_DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		wr_entry.geom.x = sat_add16(pos_x, adjust_x_q);
		wr_entry.geom.y = sat_add16(pos_y, adjust_y_q);
		wr_entry.geom.w = rect_width;
		wr_entry.geom.h = rect_height;
		wr_entry.click  = click_cmd;
		wr_entry.hover  = hover_cmd;
		wr_entry.hold   = hold_cmd;
		wr_entry.word   = user_data;
	end

	rhtt_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(AW'(count_q)),
		.wdata(wr_entry),
		.raddr(idx_q),
		.rdata(rd_raw)
	);

	assign rd_entry = rect_entry_t'(rd_raw);

	rhtt_entry_cmp u_cmp (
		.px  (px_q),
		.py  (py_q),
		.geom(rd_entry.geom),
		.hit (hit)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_type == REQ_FIND && !empty) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (chk_s1 && (hit || slot_s1 == '0)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		count_inc  = 1'b0;
		count_clr  = 1'b0;
		scan_load  = 1'b0;
		finish     = 1'b0;
		fin_hit    = 1'b0;
		fin_status = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_ADD: begin
							finish = 1'b1;
							if (full) begin
								fin_status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								count_inc = 1'b1;
							end
						end
						REQ_FIND: begin
							if (empty) begin
								finish     = 1'b1;
								fin_status = ST_NOHIT;
							end else begin
								scan_load = 1'b1;
							end
						end
						REQ_CLEAR: begin
							count_clr = 1'b1;
							finish    = 1'b1;
						end
						default: finish = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				if (chk_s1) begin
					if (hit) begin
						finish     = 1'b1;
						fin_hit    = 1'b1;
						fin_status = ST_HIT;
					end else if (slot_s1 == '0) begin
						finish     = 1'b1;
						fin_status = ST_NOHIT;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			adjust_x_q <= '0;
			adjust_y_q <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			issuing_q  <= 1'b0;
			chk_s1     <= 1'b0;
			slot_s1    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_ADJUST_X: adjust_x_q <= cfg_wdata;
					REG_ADJUST_Y: adjust_y_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (count_clr) begin
				count_q <= '0;
			end else if (count_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (scan_load) begin
				idx_q     <= AW'(count_q - 1'b1);
				issuing_q <= 1'b1;
				chk_s1    <= 1'b0;
			end else if (state_q == S_SCAN && !finish) begin
				chk_s1  <= issuing_q;
				slot_s1 <= idx_q;
				if (issuing_q) begin
					if (idx_q == '0) begin
						issuing_q <= 1'b0;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
			end else begin
				issuing_q <= 1'b0;
				chk_s1    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_load) begin
			px_q <= pos_x;
			py_q <= pos_y;
		end
	end

	assign slot_ext = 32'(slot_s1);

	always_ff @(posedge clk) begin
		if (finish) begin
			status <= fin_status;
			if (fin_hit) begin
				hit_index     <= slot_ext[3:0];
				hit_click_cmd <= rd_entry.click;
				hit_hover_cmd <= rd_entry.hover;
				hit_hold_cmd  <= rd_entry.hold;
				hit_data      <= rd_entry.word;
			end else begin
				hit_index     <= '0;
				hit_click_cmd <= '0;
				hit_hover_cmd <= '0;
				hit_hold_cmd  <= '0;
				hit_data      <= '0;
			end
		end
	end

	assign done = done_q;

endmodule

FILE: rtl/core/rhtt_ram.sv
module rhtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/rhtt_entry_cmp.sv
module rhtt_entry_cmp
	import rhtt_pkg::*;
(
	input  logic signed [15:0] px,
	input  logic signed [15:0] py,
	input  rect_geom_t         geom,
	output logic               hit
);

	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic               in_x;
	logic               in_y;

	assign dx   = {px[15], px} - {geom.x[15], geom.x};
	assign dy   = {py[15], py} - {geom.y[15], geom.y};
	assign in_x = !dx[16] && (dx < $signed({geom.w[15], geom.w}));
	assign in_y = !dy[16] && (dy < $signed({geom.h[15], geom.h}));
	assign hit  = in_x && in_y;

endmodule

FILE: dv/tb_top.sv
module tb_top;
	import rhtt_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int N_RANDOM = 1950;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum logic [1:0] {
		OP_BEAT,
		OP_CFG,
		OP_DRAIN
	} op_kind_t;

	typedef struct {
		op_kind_t           kind;
		logic [1:0]         req;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] w;
		logic signed [15:0] h;
		logic [7:0]         click;
		logic [7:0]         hover;
		logic [7:0]         hold;
		logic signed [31:0] word;
		logic               cfg_reg;
		logic [15:0]        cfg_val;
	} op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  idx;
		logic [7:0]  click;
		logic [7:0]  hover;
		logic [7:0]  hold;
		logic [31:0] data;
	} hit_res_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         req_type = REQ_NONE;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic signed [15:0] rect_width = '0;
	logic signed [15:0] rect_height = '0;
	logic [7:0]         click_cmd = '0;
	logic [7:0]         hover_cmd = '0;
	logic [7:0]         hold_cmd = '0;
	logic signed [31:0] user_data = '0;
	logic               cfg_we = 1'b0;
	logic               cfg_idx = REG_ADJUST_X;
	logic [15:0]        cfg_wdata = '0;
	logic               done;
	logic [1:0]         status;
	logic [3:0]         hit_index;
	logic [7:0]         hit_click_cmd;
	logic [7:0]         hit_hover_cmd;
	logic [7:0]         hit_hold_cmd;
	logic signed [31:0] hit_data;

	rect_hit_test_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.click_cmd     (click_cmd),
		.hover_cmd     (hover_cmd),
		.hold_cmd      (hold_cmd),
		.user_data     (user_data),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.status        (status),
		.hit_index     (hit_index),
		.hit_click_cmd (hit_click_cmd),
		.hit_hover_cmd (hit_hover_cmd),
		.hit_hold_cmd  (hit_hold_cmd),
		.hit_data      (hit_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// rectangle store as the block should hold it
	logic signed [15:0] tab_x[DEPTH];
	logic signed [15:0] tab_y[DEPTH];
	logic signed [15:0] tab_w[DEPTH];
	logic signed [15:0] tab_h[DEPTH];
	logic [7:0]         tab_click[DEPTH];
	logic [7:0]         tab_hover[DEPTH];
	logic [7:0]         tab_hold[DEPTH];
	logic [31:0]        tab_word[DEPTH];
	int                 tab_count = 0;
	logic signed [15:0] adj_x = '0;
	logic signed [15:0] adj_y = '0;

	// generator-side copy of the rectangles, used to aim finds at them
	logic signed [15:0] sh_x[DEPTH];
	logic signed [15:0] sh_y[DEPTH];
	logic signed [15:0] sh_w[DEPTH];
	logic signed [15:0] sh_h[DEPTH];
	int                 sh_count = 0;
	logic signed [15:0] g_adj_x = '0;
	logic signed [15:0] g_adj_y = '0;
	int                 n_beats = 0;

	op_t      pending_ops[$];
	hit_res_t expected_hits[$];
	int       outstanding = 0;
	int       n_errors = 0;
	int       stall_cycles = 0;
	int       gap_left = 0;
	int       quiet_left = 0;
	bit       quiet = 1'b0;

	function automatic logic signed [15:0] clamp_sum(logic signed [15:0] a,
			logic signed [15:0] b);
		int s;
		s = int'(a) + int'(b);
		if (s > 32767) begin
			return 16'sh7fff;
		end else if (s < -32768) begin
			return 16'sh8000;
		end
		return 16'(s);
	endfunction

	function automatic bit covers(logic signed [15:0] p, logic signed [15:0] o,
			logic signed [15:0] e);
		int d;
		d = int'(p) - int'(o);
		return d >= 0 && d < int'(e);
	endfunction

	function automatic hit_res_t hit_test_step(op_t op);
		hit_res_t r;
		r = '0;
		case (op.req)
			REQ_ADD: begin
				if (tab_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					tab_x[tab_count] = clamp_sum(op.px, adj_x);
					tab_y[tab_count] = clamp_sum(op.py, adj_y);
					tab_w[tab_count] = op.w;
					tab_h[tab_count] = op.h;
					tab_click[tab_count] = op.click;
					tab_hover[tab_count] = op.hover;
					tab_hold[tab_count] = op.hold;
					tab_word[tab_count] = op.word;
					tab_count++;
					r.status = ST_DONE;
				end
			end
			REQ_FIND: begin
				r.status = ST_NOHIT;
				for (int k = tab_count - 1; k >= 0; k--) begin
					if (covers(op.px, tab_x[k], tab_w[k]) && covers(op.py, tab_y[k], tab_h[k])) begin
						r.status = ST_HIT;
						r.idx = 4'(k);
						r.click = tab_click[k];
						r.hover = tab_hover[k];
						r.hold = tab_hold[k];
						r.data = tab_word[k];
						break;
					end
				end
			end
			REQ_CLEAR: begin
				tab_count = 0;
				r.status = ST_DONE;
			end
			default: begin
				r.status = ST_DONE;
			end
		endcase
		return r;
	endfunction

	function automatic int draw_gap();
		if (quiet_left == 0) begin
			quiet = $urandom_range(0, 2) == 0;
			quiet_left = $urandom_range(10, 60);
		end
		quiet_left--;
		return quiet ? 0 : $urandom_range(0, 9);
	endfunction

	// driver
	always @(posedge clk) begin
		op_t  op;
		logic start_n;
		logic we_n;
		start_n = start;
		we_n = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				start_n = 1'b0;
				gap_left = draw_gap();
			end
			if (!start_n) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() != 0) begin
					op = pending_ops[0];
					case (op.kind)
						OP_BEAT: begin
							void'(pending_ops.pop_front());
							req_type <= op.req;
							pos_x <= op.px;
							pos_y <= op.py;
							rect_width <= op.w;
							rect_height <= op.h;
							click_cmd <= op.click;
							hover_cmd <= op.hover;
							hold_cmd <= op.hold;
							user_data <= op.word;
							start_n = 1'b1;
						end
						OP_CFG: begin
							if (!start && outstanding == 0) begin
								void'(pending_ops.pop_front());
								cfg_idx <= op.cfg_reg;
								cfg_wdata <= op.cfg_val;
								we_n = 1'b1;
							end
						end
						default: begin
							if (!start && outstanding == 0) begin
								void'(pending_ops.pop_front());
							end
						end
					endcase
				end
			end
		end
		start <= start_n;
		cfg_we <= we_n;
	end

	// monitor and checker
	always @(posedge clk) begin
		hit_res_t want;
		hit_res_t got;
		op_t      seen;
		logic     took;
		if (arst_n) begin
			took = start && !busy;
			if (done) begin
				got.status = status;
				got.idx = hit_index;
				got.click = hit_click_cmd;
				got.hover = hit_hover_cmd;
				got.hold = hit_hold_cmd;
				got.data = hit_data;
				if (expected_hits.size() == 0) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("unexpected result: st=%0d idx=%0d cmd=%h/%h/%h data=%h",
							got.status, got.idx, got.click, got.hover, got.hold, got.data);
					end
				end else begin
					want = expected_hits.pop_front();
					if (want !== got) begin
						n_errors++;
						if (n_errors <= 10) begin
							$display("mismatch: exp st=%0d idx=%0d cmd=%h/%h/%h data=%h",
								want.status, want.idx, want.click, want.hover, want.hold,
								want.data);
							$display("          got st=%0d idx=%0d cmd=%h/%h/%h data=%h",
								got.status, got.idx, got.click, got.hover, got.hold, got.data);
						end
					end
				end
			end
			if (cfg_we) begin
				if (cfg_idx == REG_ADJUST_X) begin
					adj_x = cfg_wdata;
				end else begin
					adj_y = cfg_wdata;
				end
			end
			if (took) begin
				seen.kind = OP_BEAT;
				seen.req = req_type;
				seen.px = pos_x;
				seen.py = pos_y;
				seen.w = rect_width;
				seen.h = rect_height;
				seen.click = click_cmd;
				seen.hover = hover_cmd;
				seen.hold = hold_cmd;
				seen.word = user_data;
				expected_hits.push_back(hit_test_step(seen));
			end
			outstanding <= outstanding + int'(took) - int'(done);
			stall_cycles <= (took || done || cfg_we) ? 0 : stall_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[rect_hit_test_table] ERROR");
			$finish;
		end
	end

	task automatic push_req(input logic [1:0] req, input logic signed [15:0] px, py, w, h,
			input logic [7:0] click, hover, hold, input logic signed [31:0] word);
		op_t op;
		op.kind = OP_BEAT;
		op.req = req;
		op.px = px;
		op.py = py;
		op.w = w;
		op.h = h;
		op.click = click;
		op.hover = hover;
		op.hold = hold;
		op.word = word;
		op.cfg_reg = REG_ADJUST_X;
		op.cfg_val = '0;
		pending_ops.push_back(op);
		if (req != REQ_NONE) begin
			n_beats++;
		end
		if (req == REQ_ADD && sh_count < DEPTH) begin
			sh_x[sh_count] = clamp_sum(px, g_adj_x);
			sh_y[sh_count] = clamp_sum(py, g_adj_y);
			sh_w[sh_count] = w;
			sh_h[sh_count] = h;
			sh_count++;
		end else if (req == REQ_CLEAR) begin
			sh_count = 0;
		end
	endtask

	task automatic add_rect(input logic signed [15:0] x, y, w, h);
		push_req(REQ_ADD, x, y, w, h, 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic find_at(input logic signed [15:0] x, y);
		push_req(REQ_FIND, x, y, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), $urandom);
	endtask

	task automatic req_simple(input logic [1:0] req);
		push_req(req, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic set_adjust(input logic which, input logic [15:0] val);
		op_t op;
		op.kind = OP_CFG;
		op.req = REQ_NONE;
		op.cfg_reg = which;
		op.cfg_val = val;
		pending_ops.push_back(op);
		if (which == REG_ADJUST_X) begin
			g_adj_x = val;
		end else begin
			g_adj_y = val;
		end
	endtask

	task automatic hold_until_idle();
		op_t op;
		op.kind = OP_DRAIN;
		op.req = REQ_NONE;
		pending_ops.push_back(op);
	endtask

	function automatic logic [15:0] pick_adjust();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'h7fff;
			2: return 16'h8000;
			3: return 16'($urandom_range(0, 600) - 300);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic rand_rect();
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
		if ($urandom_range(0, 1) == 0) begin
			x = 16'($urandom_range(0, 400) - 200);
			y = 16'($urandom_range(0, 400) - 200);
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
		end
		if ($urandom_range(0, 9) == 0) begin
			w = 16'($urandom);
			h = 16'($urandom);
		end else begin
			w = 16'($urandom_range(1, 300));
			h = 16'($urandom_range(1, 300));
		end
		add_rect(x, y, w, h);
	endtask

	task automatic rand_find();
		int                 k;
		int                 lim_x;
		int                 lim_y;
		logic signed [15:0] px;
		logic signed [15:0] py;
		px = 16'($urandom_range(0, 400) - 200);
		py = 16'($urandom_range(0, 400) - 200);
		if ($urandom_range(0, 1) == 0) begin
			px = 16'($urandom);
			py = 16'($urandom);
		end
		if (sh_count > 0 && $urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, sh_count - 1);
			if (sh_w[k] > 0 && sh_h[k] > 0) begin
				lim_x = int'(sh_w[k]) - 1;
				lim_y = int'(sh_h[k]) - 1;
				if (int'(sh_x[k]) + lim_x > 32767) lim_x = 32767 - int'(sh_x[k]);
				if (int'(sh_y[k]) + lim_y > 32767) lim_y = 32767 - int'(sh_y[k]);
				case ($urandom_range(0, 5))
					0: begin
						px = 16'(int'(sh_x[k]) + lim_x);
						py = 16'(int'(sh_y[k]) + lim_y);
					end
					1: begin
						// just past the far edge in x, just before the near one in y
						px = sh_x[k] + sh_w[k];
						py = sh_y[k] - 16'sd1;
					end
					default: begin
						px = 16'(int'(sh_x[k]) + $urandom_range(0, lim_x));
						py = 16'(int'(sh_y[k]) + $urandom_range(0, lim_y));
					end
				endcase
			end
		end
		find_at(px, py);
	endtask

	initial begin
		int sel;

		// directed part
		set_adjust(REG_ADJUST_X, 16'h0000);
		set_adjust(REG_ADJUST_Y, 16'h0000);
		find_at(0, 0);
		add_rect(10, 20, 5, 3);
		find_at(10, 20);
		find_at(14, 22);
		find_at(15, 22);
		find_at(14, 23);
		find_at(9, 19);
		add_rect(12, 21, 4, 4);
		find_at(13, 22);
		add_rect(0, 0, 0, 5);
		add_rect(0, 0, -16'sd32768, 16'sd32767);
		find_at(0, 0);
		add_rect(16'sd32767, 16'sd32767, 100, 100);
		find_at(-16'sd32768, -16'sd32768);
		find_at(16'sd32767, 16'sd32767);
		add_rect(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
		find_at(16'sd32766, 16'sd32766);
		find_at(-16'sd32768, -16'sd32768);
		req_simple(REQ_NONE);
		find_at(10, 20);
		set_adjust(REG_ADJUST_X, 16'h7fff);
		set_adjust(REG_ADJUST_Y, 16'h8000);
		add_rect(100, -100, 1, 1);
		find_at(16'sd32767, -16'sd32768);
		while (sh_count < DEPTH) begin
			rand_rect();
		end
		add_rect(10, 20, 5, 3);
		find_at(11, 21);
		req_simple(REQ_CLEAR);
		find_at(10, 20);

		// random episodes: mostly clear then fill and probe
		while (n_beats < N_RANDOM) begin
			if ($urandom_range(0, 5) == 0) begin
				set_adjust(REG_ADJUST_X, pick_adjust());
				set_adjust(REG_ADJUST_Y, pick_adjust());
			end else if ($urandom_range(0, 7) == 0) begin
				hold_until_idle();
			end
			if ($urandom_range(0, 3) != 0) begin
				req_simple(REQ_CLEAR);
			end
			repeat ($urandom_range(5, 40)) begin
				sel = $urandom_range(0, 99);
				if (sel < 45) begin
					rand_rect();
				end else if (sel < 85) begin
					rand_find();
				end else if (sel < 88) begin
					req_simple(REQ_CLEAR);
				end else if (sel < 92) begin
					req_simple(REQ_NONE);
				end else begin
					req_simple(2'($urandom_range(0, 3)));
				end
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		do begin
			@(posedge clk);
		end while (pending_ops.size() != 0 || start || outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && expected_hits.size() == 0) begin
			$display("[rect_hit_test_table] OK");
		end else begin
			$display("[rect_hit_test_table] ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/rhtt_pkg.sv
rtl/core/rhtt_ram.sv
rtl/core/rhtt_entry_cmp.sv
rtl/core/rect_hit_test_table.sv
dv/tb_top.sv
